// ----- hw/rtl/bp128_pkg.sv -----
// ============================================================================
// bp128_pkg: shared types and constants for the BP128 block unpacker
// Word and field widths, decode modes, the slot request passed from the
// sequencer to the lanes, and the control that travels on to the merge stage.
// ============================================================================
package bp128_pkg;

    localparam int LANES  = 4;
    localparam int SLOTS  = 32;
    localparam int WORD_W = 32;
    localparam int BW_W   = 6;
    localparam int SLOT_W = 6;
    localparam int SH_W   = 5;
    localparam int POS_W  = 11;

    localparam logic [WORD_W-1:0] WORD_MASK = 32'hffff_ffff;
    localparam logic [BW_W-1:0]   FULL_WIDTH = 6'd32;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = 6'd31;

    typedef enum logic [1:0] {
        MODE_PLAIN    = 2'd0,
        MODE_DELTA    = 2'd1,
        MODE_DELTA_ZZ = 2'd2,
        MODE_FOR      = 2'd3
    } mode_t;

    // One slot request from the sequencer to every lane
    typedef struct packed {
        logic [SH_W-1:0]   sh;
        logic              use_carry;
        logic              full;
        logic              fill;
        logic [WORD_W-1:0] fill_value;
        logic [BW_W-1:0]   width;
        mode_t             mode;
        logic [WORD_W-1:0] offset;
        logic              delta;
        logic              seed;
        logic              last;
    } issue_t;

    // Control that follows the lane values into the merge stage
    typedef struct packed {
        logic              delta;
        logic              seed;
        logic              last;
        logic [WORD_W-1:0] offset;
    } merge_ctl_t;

    function automatic logic [WORD_W-1:0] unzigzag(input logic [WORD_W-1:0] v);
        return (v >> 1) ^ {WORD_W{v[0]}};
    endfunction

endpackage

// ----- hw/rtl/bp128_block_unpacker.sv -----
// ============================================================================
// bp128_block_unpacker: BP128 chunk decoder, four interleaved 32-bit lanes
// Channel  Dir  Handshake           Payload
// s_       in   s_valid / s_ready   packed_lane_0..3, bit_width, mode, offset
// m_       out  m_valid / m_ready   value_lane_0..3, last_of_chunk
//
// One decoded vector leaves per cycle while m_ready is high; a packed word is
// held until it has completed its slots (one at width 32, up to 32 at width 1,
// and 32 for a zero-width chunk), so s_ready drops at narrow widths.
// The first vector passes the word, lane and output registers in that order.
// Reset (aresetn low, synchronous) empties the pipeline and starts a chunk.
// m_ready low stalls the output register, then the lanes, then the sequencer.
// ============================================================================
module bp128_block_unpacker import bp128_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_packed_lane_0,
    input  logic [WORD_W-1:0] s_packed_lane_1,
    input  logic [WORD_W-1:0] s_packed_lane_2,
    input  logic [WORD_W-1:0] s_packed_lane_3,
    input  logic [BW_W-1:0]   s_bit_width,
    input  logic [1:0]        s_mode,
    input  logic [WORD_W-1:0] s_offset,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_value_lane_0,
    output logic [WORD_W-1:0] m_value_lane_1,
    output logic [WORD_W-1:0] m_value_lane_2,
    output logic [WORD_W-1:0] m_value_lane_3,
    output logic              m_last_of_chunk
);

    logic [LANES-1:0][WORD_W-1:0] s_lanes;
    logic [LANES-1:0][WORD_W-1:0] cur_lanes;
    logic [LANES-1:0][WORD_W-1:0] carry_lanes;
    logic [LANES-1:0][WORD_W-1:0] lane_values;
    logic [LANES-1:0][WORD_W-1:0] out_values;
    issue_t                       issue;
    logic                         issue_valid;
    logic                         issue_fire;
    logic                         s1_valid_reg;
    logic                         s1_ready;
    merge_ctl_t                   s1_ctl_reg;
    logic                         merge_ready;

    assign s_lanes = {s_packed_lane_3, s_packed_lane_2, s_packed_lane_1, s_packed_lane_0};

    bp128_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_lanes     (s_lanes),
        .s_bit_width (s_bit_width),
        .s_mode      (s_mode),
        .s_offset    (s_offset),
        .issue_valid (issue_valid),
        .issue_ready (s1_ready),
        .issue       (issue),
        .cur_lanes   (cur_lanes),
        .carry_lanes (carry_lanes)
    );

    // Lane stage: advance when the merge stage can take its contents
    assign s1_ready   = !s1_valid_reg || merge_ready;
    assign issue_fire = issue_valid && s1_ready;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bp128_lane u_lane (
            .aclk       (aclk),
            .load       (issue_fire),
            .issue      (issue),
            .cur_word   (cur_lanes[g]),
            .carry_word (carry_lanes[g]),
            .value      (lane_values[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= issue_valid;
        end
    end

    // Hold the merge control alongside the lane values
    always_ff @(posedge aclk) begin
        if (issue_fire) begin
            s1_ctl_reg.delta  <= issue.delta;
            s1_ctl_reg.seed   <= issue.seed;
            s1_ctl_reg.last   <= issue.last;
            s1_ctl_reg.offset <= issue.offset;
        end
    end

    bp128_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s1_valid_reg),
        .in_ready   (merge_ready),
        .in_values  (lane_values),
        .in_ctl     (s1_ctl_reg),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_values (out_values),
        .out_last   (m_last_of_chunk)
    );

    assign m_value_lane_0 = out_values[0];
    assign m_value_lane_1 = out_values[1];
    assign m_value_lane_2 = out_values[2];
    assign m_value_lane_3 = out_values[3];

endmodule

// ----- hw/rtl/bp128_ctrl.sv -----
// ============================================================================
// bp128_ctrl: word register and slot sequencer
// Holds the current and previous packed word, tracks the next slot's bit
// position, issues one slot request per cycle (if issue_ready) while its last
// bit is in this word. Releases the word (taking the next) on its last slot.
// ============================================================================
module bp128_ctrl import bp128_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [LANES-1:0][WORD_W-1:0] s_lanes,
    input  logic [BW_W-1:0]              s_bit_width,
    input  logic [1:0]                   s_mode,
    input  logic [WORD_W-1:0]            s_offset,
    output logic                         issue_valid,
    input  logic                         issue_ready,
    output issue_t                       issue,
    output logic [LANES-1:0][WORD_W-1:0] cur_lanes,
    output logic [LANES-1:0][WORD_W-1:0] carry_lanes
);

    logic                         loaded_reg, loaded_next;
    logic                         fill_reg, fill_next;
    logic [LANES-1:0][WORD_W-1:0] cur_reg, cur_next;
    logic [LANES-1:0][WORD_W-1:0] carry_reg, carry_next;
    logic [BW_W-1:0]              width_reg, width_next;
    mode_t                        mode_reg, mode_next;
    logic [WORD_W-1:0]            offset_reg, offset_next;
    logic [BW_W-1:0]              words_left_reg, words_left_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [POS_W-1:0]             start_reg, start_next;

    logic [BW_W-1:0]  word_idx;
    logic [POS_W-1:0] end_bit;
    logic [POS_W-1:0] next_end_bit;
    logic             end_in_word;
    logic             next_in_word;
    logic             issue_fire;
    logic             release_word;
    logic             s_fire;
    logic             chunk_start;
    logic [BW_W-1:0]  wl_after;
    logic [BW_W-1:0]  sat_width;

    // Locate the next slot relative to the current word
    assign word_idx     = width_reg - words_left_reg;
    assign end_bit      = start_reg + {5'd0, width_reg} - 11'd1;
    assign next_end_bit = start_reg + {4'd0, width_reg, 1'b0} - 11'd1;
    assign end_in_word  = (end_bit[POS_W-1:SH_W] == word_idx);
    assign next_in_word = (slot_reg != LAST_SLOT) && (next_end_bit[POS_W-1:SH_W] == word_idx);

    assign issue_valid = loaded_reg && (fill_reg || (!slot_reg[SLOT_W-1] && end_in_word));
    assign issue_fire  = issue_valid && issue_ready;

    // Release the word on its last slot, or at once if it holds none
    always_comb begin
        if (!loaded_reg) begin
            release_word = 1'b0;
        end else if (fill_reg) begin
            release_word = issue_fire && (slot_reg == LAST_SLOT);
        end else begin
            release_word = !issue_valid || (issue_fire && !next_in_word);
        end
    end

    assign s_ready     = !loaded_reg || release_word;
    assign s_fire      = s_valid && s_ready;
    assign wl_after    = (release_word && !fill_reg) ? words_left_reg - 6'd1 : words_left_reg;
    assign chunk_start = (wl_after == '0);
    assign sat_width   = (s_bit_width > FULL_WIDTH) ? FULL_WIDTH : s_bit_width;

    // Build the slot request
    always_comb begin
        issue.sh         = start_reg[SH_W-1:0];
        issue.use_carry  = (start_reg[POS_W-1:SH_W] != word_idx) && (start_reg[SH_W-1:0] != '0);
        issue.full       = (width_reg == FULL_WIDTH);
        issue.fill       = fill_reg;
        issue.fill_value = (mode_reg == MODE_PLAIN) ? '0 : offset_reg;
        issue.width      = width_reg;
        issue.mode       = mode_reg;
        issue.offset     = offset_reg;
        issue.delta      = ((mode_reg == MODE_DELTA) || (mode_reg == MODE_DELTA_ZZ))
                           && !issue.full && !fill_reg;
        issue.seed       = (slot_reg == '0);
        issue.last       = (slot_reg == LAST_SLOT);
    end

    assign cur_lanes   = cur_reg;
    assign carry_lanes = carry_reg;

    // Next state: advance the slot, retire the word, take a new request
    always_comb begin
        loaded_next     = loaded_reg;
        fill_next       = fill_reg;
        cur_next        = cur_reg;
        carry_next      = carry_reg;
        width_next      = width_reg;
        mode_next       = mode_reg;
        offset_next     = offset_reg;
        words_left_next = words_left_reg;
        slot_next       = slot_reg;
        start_next      = start_reg;

        if (issue_fire) begin
            slot_next  = slot_reg + 6'd1;
            start_next = start_reg + {5'd0, width_reg};
        end

        if (release_word) begin
            loaded_next = 1'b0;
            if (!fill_reg) begin
                carry_next      = cur_reg;
                words_left_next = wl_after;
            end
        end

        if (s_fire) begin
            loaded_next = 1'b1;
            cur_next    = s_lanes;
            if (chunk_start) begin
                width_next      = sat_width;
                mode_next       = mode_t'(s_mode);
                offset_next     = s_offset;
                words_left_next = sat_width;
                fill_next       = (sat_width == '0);
                slot_next       = '0;
                start_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg     <= 1'b0;
            fill_reg       <= 1'b0;
            width_reg      <= '0;
            mode_reg       <= MODE_PLAIN;
            offset_reg     <= '0;
            words_left_reg <= '0;
            slot_reg       <= '0;
            start_reg      <= '0;
        end else begin
            loaded_reg     <= loaded_next;
            fill_reg       <= fill_next;
            width_reg      <= width_next;
            mode_reg       <= mode_next;
            offset_reg     <= offset_next;
            words_left_reg <= words_left_next;
            slot_reg       <= slot_next;
            start_reg      <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        carry_reg <= carry_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= 6'(SLOTS))
        else $error("slot counter ran past the chunk");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg |-> (words_left_reg == '0))
        else $error("zero-width chunk with packed words outstanding");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (loaded_reg && !fill_reg) |-> (width_reg != '0) && (words_left_reg != '0))
        else $error("packed word held outside a chunk");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (loaded_reg && !fill_reg) |-> issue_valid)
        else $error("packed word holds no slot end");
`endif

endmodule

// ----- hw/rtl/bp128_lane.sv -----
// ============================================================================
// bp128_lane: one lane's value extractor
// Funnel-shifts the slot out of the current and previous word, masks it to
// the chunk width and applies frame offset or zigzag decode. Registered.
// ============================================================================
module bp128_lane import bp128_pkg::*; (
    input  logic              aclk,
    input  logic              load,
    input  issue_t            issue,
    input  logic [WORD_W-1:0] cur_word,
    input  logic [WORD_W-1:0] carry_word,
    output logic [WORD_W-1:0] value
);

    logic [2*WORD_W-1:0] pair;
    logic [WORD_W-1:0]   raw;
    logic [WORD_W-1:0]   mask;
    logic [WORD_W-1:0]   field;
    logic [WORD_W-1:0]   value_reg, value_next;

    // Pull the slot bits, spanning the word boundary when needed
    assign pair  = {cur_word, carry_word} >> issue.sh;
    assign raw   = issue.use_carry ? pair[WORD_W-1:0] : (cur_word >> issue.sh);
    assign mask  = ~(WORD_MASK << issue.width[SH_W-1:0]);
    assign field = raw & mask;

    // Decode per mode
    always_comb begin
        if (issue.fill) begin
            value_next = issue.fill_value;
        end else if (issue.full) begin
            value_next = cur_word;
        end else begin
            case (issue.mode)
                MODE_FOR:      value_next = field + issue.offset;
                MODE_DELTA_ZZ: value_next = unzigzag(field);
                MODE_DELTA:    value_next = field;
                MODE_PLAIN:    value_next = field;
                default:       value_next = field;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ----- hw/rtl/bp128_merge.sv -----
// ============================================================================
// bp128_merge: cross-lane prefix sum and output register
// In delta modes adds the running delta sum into the four lane values in
// memory order, and holds the result vector until the consumer takes it.
// ============================================================================
module bp128_merge import bp128_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [LANES-1:0][WORD_W-1:0] in_values,
    input  merge_ctl_t                   in_ctl,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [LANES-1:0][WORD_W-1:0] out_values,
    output logic                         out_last
);

    logic                         valid_reg;
    logic [LANES-1:0][WORD_W-1:0] values_reg, values_next;
    logic                         last_reg;
    logic [WORD_W-1:0]            run_reg, run_next;
    logic [WORD_W-1:0]            base;
    logic [WORD_W-1:0]            pair_lo;
    logic [WORD_W-1:0]            pair_hi;
    logic                         load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Inclusive prefix sum, seeded with the offset on a chunk's first slot
    assign base    = in_ctl.seed ? in_ctl.offset : run_reg;
    assign pair_lo = in_values[0] + in_values[1];
    assign pair_hi = in_values[2] + in_values[3];

    always_comb begin
        values_next = in_values;
        run_next    = run_reg;
        if (in_ctl.delta) begin
            values_next[0] = base + in_values[0];
            values_next[1] = base + pair_lo;
            values_next[2] = values_next[1] + in_values[2];
            values_next[3] = values_next[1] + pair_hi;
            run_next       = values_next[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            run_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                run_reg   <= run_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            values_reg <= values_next;
            last_reg   <= in_ctl.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_values = values_reg;
    assign out_last   = last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |=> $stable(run_reg))
        else $error("running sum moved while output stalled");
`endif

endmodule
